FILE: sv/bcg_pkg.sv
package bcg_pkg;

  localparam int CH_W       = 8;
  localparam int COLOR_W    = 24;
  localparam int SIZE_W     = 12;
  localparam int COORD_W    = 11;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;
  localparam int QUOT_BITS  = 8;

  localparam logic [CFG_IDX_W-1:0] REG_TOP_LEFT     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TOP_RIGHT    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BOTTOM_LEFT  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BOTTOM_RIGHT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH        = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT       = 3'd5;

  localparam logic [SIZE_W-1:0] RESET_WIDTH  = 12'd1024;
  localparam logic [SIZE_W-1:0] RESET_HEIGHT = 12'd768;

endpackage

FILE: sv/bcg_if.sv
interface bcg_req_if;
  logic                        valid;
  logic                        ready;
  logic [bcg_pkg::COORD_W-1:0] column;
  logic [bcg_pkg::COORD_W-1:0] row;

  modport source (output valid, output column, output row, input ready);
  modport sink (input valid, input column, input row, output ready);
endinterface

interface bcg_pix_if;
  logic                     valid;
  logic                     ready;
  logic [bcg_pkg::CH_W-1:0] red_out;
  logic [bcg_pkg::CH_W-1:0] green_out;
  logic [bcg_pkg::CH_W-1:0] blue_out;

  modport source (output valid, output red_out, output green_out, output blue_out,
                  input ready);
  modport sink (input valid, input red_out, input green_out, input blue_out,
                output ready);
endinterface

FILE: sv/bcg_div_cell.sv
module bcg_div_cell #(
  parameter int LANES = 1,
  parameter int DW    = 11,
  parameter int NW    = 19,
  parameter int BIT   = 7
) (
  input  logic                                          clk,
  input  logic                                          rst,
  input  logic                                          en,
  input  logic [DW-1:0]                                 divisor,
  input  logic                                          valid_in,
  input  logic [LANES-1:0][NW-1:0]                      rem_in,
  input  logic [LANES-1:0][bcg_pkg::QUOT_BITS-1:0]      quot_in,
  output logic                                          valid_out,
  output logic [LANES-1:0][NW-1:0]                      rem_out,
  output logic [LANES-1:0][bcg_pkg::QUOT_BITS-1:0]      quot_out
);

  logic [NW-1:0]                              shifted;
  logic [LANES-1:0][NW-1:0]                   rem_next;
  logic [LANES-1:0][bcg_pkg::QUOT_BITS-1:0]   quot_next;

  assign shifted = NW'(divisor) << BIT;

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      if (rem_in[i] >= shifted) begin
        rem_next[i] = rem_in[i] - shifted;
      end else begin
        rem_next[i] = rem_in[i];
      end
      quot_next[i] = {quot_in[i][bcg_pkg::QUOT_BITS-2:0], rem_in[i] >= shifted};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else if (en) begin
      valid_out <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_out  <= rem_next;
      quot_out <= quot_next;
    end
  end

endmodule

FILE: sv/bcg_div_chain.sv
module bcg_div_chain #(
  parameter int LANES = 1,
  parameter int DW    = 11,
  parameter int NW    = 19
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     en,
  input  logic [DW-1:0]                            divisor,
  input  logic                                     valid_in,
  input  logic [LANES-1:0][NW-1:0]                 num_in,
  output logic                                     valid_out,
  output logic [LANES-1:0][bcg_pkg::QUOT_BITS-1:0] quot_out
);

  localparam int STEPS = bcg_pkg::QUOT_BITS;

  logic [STEPS:0]                                   v;
  logic [STEPS:0][LANES-1:0][NW-1:0]                rem;
  logic [STEPS:0][LANES-1:0][bcg_pkg::QUOT_BITS-1:0] quot;

  assign v[0]    = valid_in;
  assign rem[0]  = num_in;
  assign quot[0] = '0;

  for (genvar s = 0; s < STEPS; s++) begin : g_cell
    bcg_div_cell #(
      .LANES(LANES),
      .DW   (DW),
      .NW   (NW),
      .BIT  (STEPS - 1 - s)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .divisor  (divisor),
      .valid_in (v[s]),
      .rem_in   (rem[s]),
      .quot_in  (quot[s]),
      .valid_out(v[s+1]),
      .rem_out  (rem[s+1]),
      .quot_out (quot[s+1])
    );
  end

  assign valid_out = v[STEPS];
  assign quot_out  = quot[STEPS];

endmodule

FILE: sv/bilinear_corner_gradient.sv
// clamp, column numerators and divider, row numerators and divider, output
// throughput: one item per cycle unless stalled, set by two chains of eight
// divider cells (one quotient bit each) after the column and row numerators
// the whole pipeline holds while the output register is full and not taken
// reset clears all valid flags, corner colours to 0, size to 1024 by 768
module bilinear_corner_gradient #(
  parameter int MAX_SIZE = 2048
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_write,
  input  logic [bcg_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [bcg_pkg::CFG_DATA_W-1:0]     cfg_data,
  bcg_req_if.sink                            request,
  bcg_pix_if.source                          pixel
);

  localparam int DW    = $clog2(MAX_SIZE);
  localparam int NW    = bcg_pkg::CH_W + DW;
  localparam int EW0   = $clog2(MAX_SIZE + 1);
  localparam int EW    = (EW0 > bcg_pkg::SIZE_W) ? EW0 : bcg_pkg::SIZE_W;
  localparam int CW    = (DW > bcg_pkg::COORD_W) ? DW : bcg_pkg::COORD_W;
  localparam int CH_W  = bcg_pkg::CH_W;
  localparam int STEPS = bcg_pkg::QUOT_BITS;

  logic [bcg_pkg::COLOR_W-1:0] top_left_color;
  logic [bcg_pkg::COLOR_W-1:0] top_right_color;
  logic [bcg_pkg::COLOR_W-1:0] bottom_left_color;
  logic [bcg_pkg::COLOR_W-1:0] bottom_right_color;
  logic [bcg_pkg::SIZE_W-1:0]  width_pixels;
  logic [bcg_pkg::SIZE_W-1:0]  height_pixels;

  always_ff @(posedge clk) begin
    if (rst) begin
      top_left_color     <= '0;
      top_right_color    <= '0;
      bottom_left_color  <= '0;
      bottom_right_color <= '0;
      width_pixels       <= bcg_pkg::RESET_WIDTH;
      height_pixels      <= bcg_pkg::RESET_HEIGHT;
    end else if (cfg_write) begin
      unique case (cfg_index)
        bcg_pkg::REG_TOP_LEFT:     top_left_color     <= cfg_data;
        bcg_pkg::REG_TOP_RIGHT:    top_right_color    <= cfg_data;
        bcg_pkg::REG_BOTTOM_LEFT:  bottom_left_color  <= cfg_data;
        bcg_pkg::REG_BOTTOM_RIGHT: bottom_right_color <= cfg_data;
        bcg_pkg::REG_WIDTH:        width_pixels       <= cfg_data[bcg_pkg::SIZE_W-1:0];
        bcg_pkg::REG_HEIGHT:       height_pixels      <= cfg_data[bcg_pkg::SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  // last index and divisor per axis; the divisor is never below one, so a size of one divides by one
  logic [EW-1:0] w_eff, h_eff;
  logic [DW-1:0] w_last, h_last, w_div, h_div;

  always_comb begin
    w_eff = EW'(width_pixels);
    h_eff = EW'(height_pixels);
    if (w_eff == '0) w_eff = EW'(1);
    if (h_eff == '0) h_eff = EW'(1);
    if (w_eff > EW'(MAX_SIZE)) w_eff = EW'(MAX_SIZE);
    if (h_eff > EW'(MAX_SIZE)) h_eff = EW'(MAX_SIZE);
    w_last = DW'(w_eff - EW'(1));
    h_last = DW'(h_eff - EW'(1));
    w_div  = (w_last == '0) ? DW'(1) : w_last;
    h_div  = (h_last == '0) ? DW'(1) : h_last;
  end

  logic en;
  assign en            = !pixel.valid || pixel.ready;
  assign request.ready = en;

  // clamp
  logic          v1;
  logic [DW-1:0] pcol1, prow1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= request.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pcol1 <= (CW'(request.column) > CW'(w_last)) ? w_last : DW'(request.column);
      prow1 <= (CW'(request.row) > CW'(h_last)) ? h_last : DW'(request.row);
    end
  end

  // column numerators: lanes 0..2 top r g b, lanes 3..5 bottom r g b
  logic                  v2;
  logic [5:0][NW-1:0]    num_col;
  logic [5:0][NW-1:0]    num_col_next;
  logic [DW-1:0]         prow2;
  logic [NW-1:0]         wl, wr;

  assign wl = NW'(w_div - pcol1);
  assign wr = NW'(pcol1);

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      num_col_next[k] =
        NW'(top_left_color[(2-k)*CH_W +: CH_W]) * wl +
        NW'(top_right_color[(2-k)*CH_W +: CH_W]) * wr;
      num_col_next[k+3] =
        NW'(bottom_left_color[(2-k)*CH_W +: CH_W]) * wl +
        NW'(bottom_right_color[(2-k)*CH_W +: CH_W]) * wr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num_col <= num_col_next;
      prow2   <= prow1;
    end
  end

  logic                        vc;
  logic [5:0][STEPS-1:0]       q_col;

  bcg_div_chain #(.LANES(6), .DW(DW), .NW(NW)) u_col_div (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .divisor  (w_div),
    .valid_in (v2),
    .num_in   (num_col),
    .valid_out(vc),
    .quot_out (q_col)
  );

  // row travels beside the column chain
  logic [STEPS-1:0][DW-1:0] row_line;

  always_ff @(posedge clk) begin
    if (en) begin
      row_line[0] <= prow2;
      for (int s = 1; s < STEPS; s++) begin
        row_line[s] <= row_line[s-1];
      end
    end
  end

  // row numerators
  logic               v3;
  logic [2:0][NW-1:0] num_row;
  logic [2:0][NW-1:0] num_row_next;
  logic [NW-1:0]      ht, hb;

  assign ht = NW'(h_div - row_line[STEPS-1]);
  assign hb = NW'(row_line[STEPS-1]);

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      num_row_next[k] = NW'(q_col[k]) * ht + NW'(q_col[k+3]) * hb;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= vc;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num_row <= num_row_next;
    end
  end

  logic                  vr;
  logic [2:0][STEPS-1:0] q_row;

  bcg_div_chain #(.LANES(3), .DW(DW), .NW(NW)) u_row_div (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .divisor  (h_div),
    .valid_in (v3),
    .num_in   (num_row),
    .valid_out(vr),
    .quot_out (q_row)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel.valid <= 1'b0;
    end else if (en) begin
      pixel.valid <= vr;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pixel.red_out   <= q_row[0];
      pixel.green_out <= q_row[1];
      pixel.blue_out  <= q_row[2];
    end
  end

  a_reset_empty : assert property (@(posedge clk) $past(rst) |-> !pixel.valid)
    else $error("pixel valid after reset");

  a_stall_blocks : assert property (@(posedge clk) disable iff (rst)
    (pixel.valid && !pixel.ready) |-> !request.ready)
    else $error("request taken while output stalled");

  a_divisor_nonzero : assert property (@(posedge clk) disable iff (rst)
    (w_div != '0) && (h_div != '0))
    else $error("zero divisor");

  a_hold_output : assert property (@(posedge clk) disable iff (rst)
    (pixel.valid && !pixel.ready) |=> (pixel.valid && $stable(pixel.red_out)))
    else $error("stalled pixel changed");

endmodule
